[rtl/core/msl_pkg.sv]
// Shared types, codes and constants for the MessagePack string locator.
package msl_pkg;

  localparam int unsigned MaxBatch = 256;
  localparam int unsigned RecW     = $clog2(MaxBatch + 1);
  localparam int unsigned MsW      = 9;
  localparam int unsigned LimW     = (RecW > MsW) ? RecW : MsW;
  localparam int unsigned SkipW    = 5;
  localparam int unsigned CfgDataW = 9;

  // request types
  localparam logic ReqBegin = 1'b0;
  localparam logic ReqData  = 1'b1;

  // configuration register indexes
  localparam logic [0:0] CfgMaxStrings = 1'b0;
  localparam logic [0:0] CfgAsciiSkip  = 1'b1;

  localparam logic [8:0] MaxStringsRst = 9'd256;
  localparam logic [4:0] AsciiSkipRst  = 5'd8;

  // token codes
  localparam logic [7:0] TokFixStrLo = 8'ha0;
  localparam logic [7:0] TokFixStrHi = 8'hc0;
  localparam logic [7:0] TokBin8     = 8'hc4;
  localparam logic [7:0] TokBin16    = 8'hc5;
  localparam logic [7:0] TokBin32    = 8'hc6;
  localparam logic [7:0] TokExt8     = 8'hc7;
  localparam logic [7:0] TokExt16    = 8'hc8;
  localparam logic [7:0] TokExt32    = 8'hc9;
  localparam logic [7:0] TokFloat32  = 8'hca;
  localparam logic [7:0] TokFloat64  = 8'hcb;
  localparam logic [7:0] TokUint8    = 8'hcc;
  localparam logic [7:0] TokUint16   = 8'hcd;
  localparam logic [7:0] TokUint32   = 8'hce;
  localparam logic [7:0] TokUint64   = 8'hcf;
  localparam logic [7:0] TokInt8     = 8'hd0;
  localparam logic [7:0] TokInt16    = 8'hd1;
  localparam logic [7:0] TokInt32    = 8'hd2;
  localparam logic [7:0] TokInt64    = 8'hd3;
  localparam logic [7:0] TokFixExt1  = 8'hd4;
  localparam logic [7:0] TokFixExt2  = 8'hd5;
  localparam logic [7:0] TokFixExt4  = 8'hd6;
  localparam logic [7:0] TokFixExt8  = 8'hd7;
  localparam logic [7:0] TokFixExt16 = 8'hd8;
  localparam logic [7:0] TokStr8     = 8'hd9;
  localparam logic [7:0] TokStr16    = 8'hda;
  localparam logic [7:0] TokStr32    = 8'hdb;
  localparam logic [7:0] TokArray16  = 8'hdc;
  localparam logic [7:0] TokArray32  = 8'hdd;
  localparam logic [7:0] TokMap16    = 8'hde;
  localparam logic [7:0] TokMap32    = 8'hdf;

  typedef enum logic [2:0] {
    PhToken,
    PhLen,
    PhExtLen,
    PhExtType,
    PhSkip,
    PhShort
  } phase_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] start_offset;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        string_found;
    logic [31:0] string_offset;
    logic [31:0] string_length;
    logic        batch_end;
    logic        batch_full;
    logic        truncated;
    logic [31:0] next_offset;
  } out_beat_t;

  typedef struct packed {
    phase_e            phase;
    logic [31:0]       byte_offset;
    logic [31:0]       length_accum;
    logic [2:0]        hdr_left;
    logic [31:0]       payload_left;
    logic              pending_is_string;
    logic              short_high;
    logic [31:0]       pending_start;
    logic [RecW-1:0]   records;
    logic              stopped;
  } scan_state_t;

  // idle until a begin beat
  localparam scan_state_t ScanStateRst = '{
    phase:             PhToken,
    byte_offset:       32'd0,
    length_accum:      32'd0,
    hdr_left:          3'd0,
    payload_left:      32'd0,
    pending_is_string: 1'b0,
    short_high:        1'b0,
    pending_start:     32'd0,
    records:           '0,
    stopped:           1'b1
  };

endpackage

[rtl/core/msgpack_string_locator_top.sv]
// Top level of the MessagePack string locator.
//
//   port group  dir  handshake           beat
//   in_*        in   valid / ready       msl_pkg::in_beat_t
//   out_*       out  valid / ready       msl_pkg::out_beat_t
//   cfg_*       in   write enable only   index + 9-bit data
//
// One beat per cycle while ready: each byte updates the scan state in the
// cycle it is taken; its record, if any, enters the output register the
// next cycle, or the skid stage when the output register is still held.
// Input ready drops only when both the output register and skid stage hold
// records. Reset leaves the block idle until a begin beat; configuration
// returns to max_strings 256, ascii_skip_below 8.
module msgpack_string_locator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msl_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msl_pkg::out_beat_t out_beat_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [msl_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [8:0]           max_strings_q;
  logic [4:0]           ascii_skip_q;
  msl_pkg::scan_state_t state_q;
  msl_pkg::scan_state_t state_d;
  logic                 res_valid;
  msl_pkg::out_beat_t   res;
  logic                 accept;
  logic                 push;

  assign accept = in_valid_i & in_ready_o;
  assign push   = accept & res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_strings_q <= msl_pkg::MaxStringsRst;
      ascii_skip_q  <= msl_pkg::AsciiSkipRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msl_pkg::CfgMaxStrings: max_strings_q <= cfg_data_i[8:0];
        msl_pkg::CfgAsciiSkip:  ascii_skip_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msl_pkg::ScanStateRst;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  msl_decode u_decode (
    .state_i       (state_q),
    .beat_i        (in_beat_i),
    .max_strings_i (max_strings_q),
    .ascii_skip_i  (ascii_skip_q),
    .state_o       (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  msl_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_beat_i  (res),
    .push_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_o   (out_beat_o)
  );

  a_begin_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_beat_i.req_type == msl_pkg::ReqBegin) |-> !push)
    else $error("begin beat produced a record");

  a_bare_record_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_beat_o.string_found) |->
      (out_beat_o.batch_end && out_beat_o.string_offset == '0 &&
       out_beat_o.string_length == '0))
    else $error("record without string must close the batch");

  a_full_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.batch_full) |-> out_beat_o.batch_end)
    else $error("full batch not marked as ended");

  a_stop_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.batch_end) |=> state_q.stopped)
    else $error("scan still running after batch end");

endmodule

[rtl/core/msl_decode.sv]
// Per-beat token decoder: next scan state and result record.
module msl_decode (
  input  msl_pkg::scan_state_t state_i,
  input  msl_pkg::in_beat_t    beat_i,
  input  logic [8:0]           max_strings_i,
  input  logic [4:0]           ascii_skip_i,
  output msl_pkg::scan_state_t state_o,
  output logic                 res_valid_o,
  output msl_pkg::out_beat_t   res_o
);

  msl_pkg::scan_state_t        st;
  logic                        found;
  logic [31:0]                 so;
  logic [31:0]                 sl;
  logic                        full;
  logic                        last;
  logic                        fin;
  logic [7:0]                  b;
  logic [4:0]                  fix_len;
  logic [31:0]                 acc_new;
  logic [2:0]                  hdr_new;
  logic [31:0]                 pl_new;
  logic                        hh_new;
  logic [msl_pkg::SkipW-1:0]   skip_n;
  logic                        do_skip;
  logic                        do_hdr;
  logic [2:0]                  hdr_n;
  logic                        hdr_str;
  logic                        hdr_ext;
  logic [msl_pkg::LimW-1:0]    ms_ext;
  logic [msl_pkg::LimW-1:0]    limit;
  logic [msl_pkg::RecW-1:0]    rec_new;

  assign b       = beat_i.data_byte;
  assign last    = beat_i.last_byte;
  assign fix_len = b[4:0];
  assign ms_ext  = msl_pkg::LimW'(max_strings_i);

  always_comb begin
    if (ms_ext == '0) begin
      limit = msl_pkg::LimW'(1);
    end else if (ms_ext > msl_pkg::LimW'(msl_pkg::MaxBatch)) begin
      limit = msl_pkg::LimW'(msl_pkg::MaxBatch);
    end else begin
      limit = ms_ext;
    end
  end

  // header / skip classification of a token byte above fixstr range
  always_comb begin
    do_skip = 1'b0;
    skip_n  = '0;
    do_hdr  = 1'b0;
    hdr_n   = 3'd0;
    hdr_str = 1'b0;
    hdr_ext = 1'b0;
    case (b)
      msl_pkg::TokStr8:    begin do_hdr = 1'b1; hdr_n = 3'd1; hdr_str = 1'b1; end
      msl_pkg::TokStr16:   begin do_hdr = 1'b1; hdr_n = 3'd2; hdr_str = 1'b1; end
      msl_pkg::TokStr32:   begin do_hdr = 1'b1; hdr_n = 3'd4; hdr_str = 1'b1; end
      msl_pkg::TokBin8:    begin do_hdr = 1'b1; hdr_n = 3'd1; end
      msl_pkg::TokBin16:   begin do_hdr = 1'b1; hdr_n = 3'd2; end
      msl_pkg::TokBin32:   begin do_hdr = 1'b1; hdr_n = 3'd4; end
      msl_pkg::TokExt8:    begin do_hdr = 1'b1; hdr_n = 3'd1; hdr_ext = 1'b1; end
      msl_pkg::TokExt16:   begin do_hdr = 1'b1; hdr_n = 3'd2; hdr_ext = 1'b1; end
      msl_pkg::TokExt32:   begin do_hdr = 1'b1; hdr_n = 3'd4; hdr_ext = 1'b1; end
      msl_pkg::TokUint8,
      msl_pkg::TokInt8:    begin do_skip = 1'b1; skip_n = 5'd1; end
      msl_pkg::TokUint16,
      msl_pkg::TokInt16,
      msl_pkg::TokArray16,
      msl_pkg::TokMap16,
      msl_pkg::TokFixExt1: begin do_skip = 1'b1; skip_n = 5'd2; end
      msl_pkg::TokFixExt2: begin do_skip = 1'b1; skip_n = 5'd3; end
      msl_pkg::TokUint32,
      msl_pkg::TokInt32,
      msl_pkg::TokFloat32,
      msl_pkg::TokArray32,
      msl_pkg::TokMap32:   begin do_skip = 1'b1; skip_n = 5'd4; end
      msl_pkg::TokFixExt4: begin do_skip = 1'b1; skip_n = 5'd5; end
      msl_pkg::TokUint64,
      msl_pkg::TokInt64,
      msl_pkg::TokFloat64: begin do_skip = 1'b1; skip_n = 5'd8; end
      msl_pkg::TokFixExt8: begin do_skip = 1'b1; skip_n = 5'd9; end
      msl_pkg::TokFixExt16: begin do_skip = 1'b1; skip_n = 5'd17; end
      default: ;
    endcase
  end

  assign acc_new = {state_i.length_accum[23:0], b};
  assign hdr_new = (state_i.hdr_left != 3'd0) ? state_i.hdr_left - 3'd1 : 3'd0;
  assign pl_new  = (state_i.payload_left != '0) ? state_i.payload_left - 32'd1 : '0;
  assign hh_new  = state_i.short_high | b[7];

  always_comb begin
    st          = state_i;
    found       = 1'b0;
    so          = '0;
    sl          = '0;
    full        = 1'b0;
    fin         = 1'b0;
    rec_new     = state_i.records;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (beat_i.req_type == msl_pkg::ReqBegin) begin
      st             = '0;
      st.phase       = msl_pkg::PhToken;
      st.byte_offset = beat_i.start_offset;
    end else if (!state_i.stopped) begin
      st.byte_offset = state_i.byte_offset + 32'd1;
      case (state_i.phase)
        msl_pkg::PhToken: begin
          if (b < msl_pkg::TokFixStrLo) begin
            st.phase = msl_pkg::PhToken;
          end else if (b < msl_pkg::TokFixStrHi) begin
            if (fix_len >= ascii_skip_i) begin
              found           = 1'b1;
              so              = st.byte_offset;
              sl              = 32'(fix_len);
              st.payload_left = 32'(fix_len);
              st.phase        = (fix_len != '0) ? msl_pkg::PhSkip : msl_pkg::PhToken;
            end else if (fix_len != '0) begin
              st.phase         = msl_pkg::PhShort;
              st.payload_left  = 32'(fix_len);
              st.length_accum  = 32'(fix_len);
              st.pending_start = st.byte_offset;
              st.short_high    = 1'b0;
            end
          end else if (do_hdr) begin
            st.hdr_left          = hdr_n;
            st.length_accum      = '0;
            st.pending_is_string = hdr_str;
            st.phase             = hdr_ext ? msl_pkg::PhExtLen : msl_pkg::PhLen;
          end else if (do_skip) begin
            st.payload_left = 32'(skip_n);
            st.phase        = msl_pkg::PhSkip;
          end
        end
        msl_pkg::PhLen,
        msl_pkg::PhExtLen: begin
          st.length_accum = acc_new;
          st.hdr_left     = hdr_new;
          if (hdr_new == 3'd0) begin
            if (state_i.phase == msl_pkg::PhExtLen) begin
              st.phase = msl_pkg::PhExtType;
            end else begin
              if (state_i.pending_is_string) begin
                found = 1'b1;
                so    = st.byte_offset;
                sl    = acc_new;
              end
              st.pending_is_string = 1'b0;
              st.payload_left      = acc_new;
              st.phase = (acc_new != '0) ? msl_pkg::PhSkip : msl_pkg::PhToken;
            end
          end
        end
        msl_pkg::PhExtType: begin
          st.payload_left = state_i.length_accum;
          st.phase = (state_i.length_accum != '0) ? msl_pkg::PhSkip : msl_pkg::PhToken;
        end
        msl_pkg::PhSkip: begin
          st.payload_left = pl_new;
          if (pl_new == '0) begin
            st.phase = msl_pkg::PhToken;
          end
        end
        msl_pkg::PhShort: begin
          st.short_high   = hh_new;
          st.payload_left = pl_new;
          if (pl_new == '0) begin
            st.phase = msl_pkg::PhToken;
            if (hh_new) begin
              found = 1'b1;
              so    = state_i.pending_start;
              sl    = state_i.length_accum;
            end
            st.short_high = 1'b0;
          end
        end
        default: st.phase = msl_pkg::PhToken;
      endcase

      // region ends inside a short fixstr that already has a high byte
      if (last && st.phase == msl_pkg::PhShort && st.short_high) begin
        found = 1'b1;
        so    = st.pending_start;
        sl    = st.length_accum;
      end
      if (found) begin
        rec_new = state_i.records + msl_pkg::RecW'(1);
        full    = (msl_pkg::LimW'(rec_new) >= limit);
      end
      st.records = rec_new;
      fin        = full | last;
      if (fin) begin
        st.stopped = 1'b1;
      end
      res_valid_o         = found | fin;
      res_o.string_found  = found;
      res_o.string_offset = so;
      res_o.string_length = sl;
      res_o.batch_end     = fin;
      res_o.batch_full    = full;
      res_o.truncated     = last && (st.phase == msl_pkg::PhLen ||
                                     st.phase == msl_pkg::PhExtLen ||
                                     st.phase == msl_pkg::PhExtType);
      res_o.next_offset   = st.byte_offset + st.payload_left;
    end
    state_o = st;
  end

endmodule

[rtl/core/msl_skid.sv]
// Two-entry result buffer: output register plus skid stage.
module msl_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  msl_pkg::out_beat_t push_beat_i,
  output logic               push_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msl_pkg::out_beat_t out_beat_o
);

  logic               main_vld_q;
  logic               skid_vld_q;
  msl_pkg::out_beat_t main_q;
  msl_pkg::out_beat_t skid_q;
  logic               pop;

  assign pop          = main_vld_q & out_ready_i;
  assign push_ready_o = ~skid_vld_q;
  assign out_valid_o  = main_vld_q;
  assign out_beat_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_vld_q <= 1'b1;
        skid_vld_q <= push_i;
      end else begin
        main_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_q <= skid_q;
        skid_q <= push_beat_i;
      end else begin
        main_q <= push_beat_i;
      end
    end else if (push_i) begin
      skid_q <= push_beat_i;
    end
  end

endmodule
